// ----- rtl/core/bpa_pkg.sv -----
// shared types, constants and helpers of the buddy page allocator
package bpa_pkg;

   localparam int NUM_PAGES  = 1024;
   localparam int MAX_ORDERS = 11;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int LINK_W     = PAGE_W + 1;
   localparam int ORD_W      = 4;
   localparam int TOP_LVL    = MAX_ORDERS - 1;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FREE  = 2'd1,
      ST_ORDER    = 2'd2,
      ST_MISALIGN = 2'd3
   } stat_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_CHECK,
      OP_LVL_INC,
      OP_EMPTY,
      OP_TAKE,
      OP_UNL_RD,
      OP_UNL_WR,
      OP_LVL_DEC,
      OP_SPLIT_DONE,
      OP_PUSH1,
      OP_PUSH2,
      OP_TOG_RD,
      OP_TOG_WR,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   req_ready;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic rsp_free;
      logic kind;
      logic ord_bad;
      logic misalign;
      logic head_nz;
      logic lvl_top;
      logic lvl_gt_ord;
      logic was;
      logic clr_last;
   } sts_type;

   // pair bit position: per-order base plus pair number
   function automatic logic [PAGE_W-1:0] pair_pos(input logic [ORD_W-1:0] lvl,
                                                  input logic [PAGE_W-1:0] page);
      logic [PAGE_W:0] base;
      logic [PAGE_W:0] pair;
      base = (PAGE_W+1)'(NUM_PAGES) - ((PAGE_W+1)'(NUM_PAGES) >> lvl);
      pair = (PAGE_W+1)'(page >> ({1'b0, lvl} + 5'd1));
      return PAGE_W'(base + pair);
   endfunction

endpackage

// ----- rtl/core/bpa_req_if.sv -----
// request channel of the buddy page allocator
interface bpa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [bpa_pkg::ORD_W-1:0]      order;
   logic [bpa_pkg::PAGE_W-1:0]     block_index;

   modport source (output valid, output req_type, output order, output block_index,
                   input ready);
   modport sink   (input valid, input req_type, input order, input block_index,
                   output ready);
endinterface

// ----- rtl/core/bpa_rsp_if.sv -----
// response channel of the buddy page allocator
interface bpa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpa_pkg::PAGE_W-1:0]     block_index_res;
   logic [1:0]                     status;

   modport source (output valid, output block_index_res, output status, input ready);
   modport sink   (input valid, input block_index_res, input status, output ready);
endinterface

// ----- rtl/core/bpa_ram.sv -----
// generic single write port ram with registered read
module bpa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/bpa_ctrl.sv -----
// sequencing state machine of the buddy page allocator
module bpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  bpa_pkg::sts_type  sts,
   output bpa_pkg::cmd_type  cmd
);
   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_CHECK  = 12'b0000_0000_0100,
      S_SCAN   = 12'b0000_0000_1000,
      S_UNL_RD = 12'b0000_0001_0000,
      S_UNL_WR = 12'b0000_0010_0000,
      S_SPLIT  = 12'b0000_0100_0000,
      S_PUSH1  = 12'b0000_1000_0000,
      S_PUSH2  = 12'b0001_0000_0000,
      S_MERGE  = 12'b0010_0000_0000,
      S_TOG    = 12'b0100_0000_0000,
      S_DONE   = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = bpa_pkg::OP_NONE;
      cmd.req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = bpa_pkg::OP_CLEAR;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (sts.req_valid) begin
               cmd.op   = bpa_pkg::OP_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.op = bpa_pkg::OP_CHECK;
            if (sts.ord_bad) begin
               state_in = S_DONE;
            end else if (sts.kind == bpa_pkg::REQ_ALLOC) begin
               state_in = S_SCAN;
            end else if (sts.misalign) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MERGE;
            end
         end
         S_SCAN: begin
            if (sts.head_nz) begin
               cmd.op   = bpa_pkg::OP_TAKE;
               state_in = S_UNL_RD;
            end else if (sts.lvl_top) begin
               cmd.op   = bpa_pkg::OP_EMPTY;
               state_in = S_DONE;
            end else begin
               cmd.op = bpa_pkg::OP_LVL_INC;
            end
         end
         S_UNL_RD: begin
            cmd.op   = bpa_pkg::OP_UNL_RD;
            state_in = S_UNL_WR;
         end
         S_UNL_WR: begin
            cmd.op   = bpa_pkg::OP_UNL_WR;
            state_in = (sts.kind == bpa_pkg::REQ_ALLOC) ? S_SPLIT : S_MERGE;
         end
         S_SPLIT: begin
            if (sts.lvl_gt_ord) begin
               cmd.op   = bpa_pkg::OP_LVL_DEC;
               state_in = S_PUSH1;
            end else begin
               cmd.op   = bpa_pkg::OP_SPLIT_DONE;
               state_in = S_DONE;
            end
         end
         S_PUSH1: begin
            cmd.op   = bpa_pkg::OP_PUSH1;
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            cmd.op   = bpa_pkg::OP_PUSH2;
            state_in = (sts.kind == bpa_pkg::REQ_ALLOC) ? S_SPLIT : S_DONE;
         end
         S_MERGE: begin
            if (sts.lvl_top) begin
               state_in = S_PUSH1;
            end else begin
               cmd.op   = bpa_pkg::OP_TOG_RD;
               state_in = S_TOG;
            end
         end
         S_TOG: begin
            cmd.op   = bpa_pkg::OP_TOG_WR;
            state_in = sts.was ? S_UNL_RD : S_PUSH1;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.op   = bpa_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

// ----- rtl/core/bpa_datapath.sv -----
// free lists, link memories, pair bits and response register
module bpa_datapath (
   input  logic              clock,
   input  logic              reset,
   bpa_req_if.sink           req_ch,
   bpa_rsp_if.source         rsp_ch,
   input  bpa_pkg::cmd_type  cmd,
   output bpa_pkg::sts_type  sts
);
   localparam int PW = bpa_pkg::PAGE_W;
   localparam int LW = bpa_pkg::LINK_W;
   localparam int OW = bpa_pkg::ORD_W;

   logic                 kind_ff;
   logic [OW-1:0]        ord_ff;
   logic [OW-1:0]        lvl_ff;
   logic [PW-1:0]        page_ff;
   logic [LW-1:0]        h_ff;
   logic [PW-1:0]        res_ff;
   bpa_pkg::stat_type    stat_ff;
   logic                 rsp_valid_ff;
   logic [PW-1:0]        rsp_res_ff;
   bpa_pkg::stat_type    rsp_stat_ff;
   logic [PW-1:0]        clr_ff;
   logic [LW-1:0]        heads_ff [bpa_pkg::MAX_ORDERS];

   logic                 next_we, prev_we, pair_we;
   logic [PW-1:0]        next_waddr, prev_waddr, pair_waddr;
   logic [LW-1:0]        next_wdata, prev_wdata;
   logic                 pair_wdata;
   logic [PW-1:0]        link_raddr, pos;
   logic [LW-1:0]        n_rd, p_rd;
   logic                 pair_rd;

   logic [PW-1:0]        bit_mask;
   logic [LW-1:0]        head_cur;
   logic                 ord_bad, misalign;
   logic [PW+1:0]        span_end;

   assign bit_mask   = PW'(1) << lvl_ff;
   assign link_raddr = (kind_ff == bpa_pkg::REQ_FREE) ? (page_ff ^ bit_mask) : page_ff;
   assign pos        = bpa_pkg::pair_pos(lvl_ff, page_ff);
   assign head_cur   = heads_ff[lvl_ff];
   assign ord_bad    = ord_ff >= OW'(bpa_pkg::MAX_ORDERS);
   assign span_end   = {2'b00, page_ff} + ((PW+2)'(1) << ord_ff);
   assign misalign   = ((page_ff & ~({PW{1'b1}} << ord_ff)) != '0)
                    || (span_end > (PW+2)'(bpa_pkg::NUM_PAGES));

   bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_next_ram (
      .clock(clock), .wr_en(next_we), .wr_addr(next_waddr), .wr_data(next_wdata),
      .rd_addr(link_raddr), .rd_data(n_rd)
   );
   bpa_ram #(.WIDTH(LW), .DEPTH(bpa_pkg::NUM_PAGES)) u_prev_ram (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_waddr), .wr_data(prev_wdata),
      .rd_addr(link_raddr), .rd_data(p_rd)
   );
   bpa_ram #(.WIDTH(1), .DEPTH(bpa_pkg::NUM_PAGES)) u_pair_ram (
      .clock(clock), .wr_en(pair_we), .wr_addr(pair_waddr), .wr_data(pair_wdata),
      .rd_addr(pos), .rd_data(pair_rd)
   );

   always_comb begin
      next_we    = 1'b0;
      next_waddr = page_ff;
      next_wdata = head_cur;
      prev_we    = 1'b0;
      prev_waddr = page_ff;
      prev_wdata = '0;
      pair_we    = 1'b0;
      pair_waddr = pos;
      pair_wdata = ~pair_rd;
      case (cmd.op)
         bpa_pkg::OP_CLEAR: begin
            pair_we    = 1'b1;
            pair_waddr = clr_ff;
            pair_wdata = 1'b0;
         end
         bpa_pkg::OP_UNL_WR: begin
            if (p_rd != '0) begin
               next_we    = 1'b1;
               next_waddr = PW'(p_rd - LW'(1));
               next_wdata = n_rd;
            end
            if (n_rd != '0) begin
               prev_we    = 1'b1;
               prev_waddr = PW'(n_rd - LW'(1));
               prev_wdata = p_rd;
            end
            pair_we = (kind_ff == bpa_pkg::REQ_ALLOC) && (lvl_ff != OW'(bpa_pkg::TOP_LVL));
         end
         bpa_pkg::OP_PUSH1: begin
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         bpa_pkg::OP_PUSH2: begin
            prev_we    = h_ff != '0;
            prev_waddr = PW'(h_ff - LW'(1));
            prev_wdata = {1'b0, page_ff} + LW'(1);
            pair_we    = kind_ff == bpa_pkg::REQ_ALLOC;
         end
         bpa_pkg::OP_TOG_WR: begin
            pair_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         for (int k = 0; k < bpa_pkg::MAX_ORDERS; k++) begin
            heads_ff[k] <= '0;
         end
      end else begin
         if (cmd.op == bpa_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            bpa_pkg::OP_CLEAR: begin
               clr_ff <= clr_ff + PW'(1);
            end
            bpa_pkg::OP_LOAD: begin
               kind_ff <= req_ch.req_type;
               ord_ff  <= req_ch.order;
               page_ff <= req_ch.block_index;
            end
            bpa_pkg::OP_CHECK: begin
               res_ff <= '0;
               if (ord_bad) begin
                  stat_ff <= bpa_pkg::ST_ORDER;
               end else if (kind_ff == bpa_pkg::REQ_FREE && misalign) begin
                  stat_ff <= bpa_pkg::ST_MISALIGN;
               end else begin
                  stat_ff <= bpa_pkg::ST_OK;
               end
               if (!ord_bad) begin
                  lvl_ff <= ord_ff;
               end
            end
            bpa_pkg::OP_LVL_INC: begin
               lvl_ff <= lvl_ff + OW'(1);
            end
            bpa_pkg::OP_EMPTY: begin
               stat_ff <= bpa_pkg::ST_NO_FREE;
            end
            bpa_pkg::OP_TAKE: begin
               page_ff <= PW'(head_cur - LW'(1));
            end
            bpa_pkg::OP_UNL_WR: begin
               if (p_rd == '0) begin
                  heads_ff[lvl_ff] <= n_rd;
               end
               if (kind_ff == bpa_pkg::REQ_FREE) begin
                  page_ff <= page_ff & ~bit_mask;
                  lvl_ff  <= lvl_ff + OW'(1);
               end
            end
            bpa_pkg::OP_LVL_DEC: begin
               lvl_ff <= lvl_ff - OW'(1);
            end
            bpa_pkg::OP_SPLIT_DONE: begin
               res_ff <= page_ff;
            end
            bpa_pkg::OP_PUSH1: begin
               h_ff <= head_cur;
            end
            bpa_pkg::OP_PUSH2: begin
               heads_ff[lvl_ff] <= {1'b0, page_ff} + LW'(1);
               if (kind_ff == bpa_pkg::REQ_ALLOC) begin
                  page_ff <= page_ff + bit_mask;
               end
            end
            bpa_pkg::OP_EMIT: begin
               rsp_res_ff  <= res_ff;
               rsp_stat_ff <= stat_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign req_ch.ready           = cmd.req_ready;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.block_index_res = rsp_res_ff;
   assign rsp_ch.status          = rsp_stat_ff;

   assign sts.req_valid  = req_ch.valid;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign sts.kind       = kind_ff;
   assign sts.ord_bad    = ord_bad;
   assign sts.misalign   = misalign;
   assign sts.head_nz    = head_cur != '0;
   assign sts.lvl_top    = lvl_ff == OW'(bpa_pkg::TOP_LVL);
   assign sts.lvl_gt_ord = lvl_ff > ord_ff;
   assign sts.was        = pair_rd;
   assign sts.clr_last   = clr_ff == {PW{1'b1}};

   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stat_ff != bpa_pkg::ST_OK |-> rsp_res_ff == '0)
      else $error("failed request carries a nonzero block index");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bpa_pkg::OP_EMIT |-> !rsp_valid_ff || rsp_ch.ready)
      else $error("pending response overwritten");

   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bpa_pkg::OP_PUSH1 |-> lvl_ff <= OW'(bpa_pkg::TOP_LVL))
      else $error("push at an order beyond the top list");

   a_no_top_toggle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bpa_pkg::OP_TOG_WR |-> lvl_ff != OW'(bpa_pkg::TOP_LVL))
      else $error("pair bit toggled at the top order");
endmodule

// ----- rtl/core/buddy_page_allocator.sv -----
// binary buddy page allocator top level
// after reset the pair bits are cleared; no request is taken meanwhile
// one request at a time; a response register lets the next request in while one waits
// allocate: s lists scanned (1..11), then d split steps (0..10);
// no free block: the scan ends at the top order
// free: m merges (0..10), merging stops at the top order;
// bad order or alignment: the response is sent without touching the lists
module buddy_page_allocator (
   input  logic       clock,
   input  logic       reset,
   bpa_req_if.sink    req_ch,
   bpa_rsp_if.source  rsp_ch
);
   bpa_pkg::cmd_type cmd;
   bpa_pkg::sts_type sts;

   bpa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   bpa_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .sts    (sts)
   );
endmodule

// ----- tb/buddy_page_allocator_checker.sv -----
// checker: tracks the free lists and pair bits, predicts every response and compares
module buddy_page_allocator_checker
   import bpa_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   bpa_req_if    req,
   bpa_rsp_if    rsp,
   output int    fails,
   output int    waiting
);

   localparam int PAIR_DEPTH = NUM_PAGES + MAX_ORDERS;

   typedef struct {
      logic [PAGE_W-1:0] idx;
      stat_type          st;
   } alloc_result_t;

   logic [LINK_W-1:0] free_head [MAX_ORDERS];
   logic [LINK_W-1:0] fwd_link  [NUM_PAGES];
   logic [LINK_W-1:0] back_link [NUM_PAGES];
   logic              buddy_bit [PAIR_DEPTH];
   int                bit_base  [MAX_ORDERS];
   alloc_result_t     pending_results [$];

   function automatic logic flip_buddy(int lvl, int page);
      int  pos;
      logic was;
      pos = bit_base[lvl] + (page >> (lvl + 1));
      if (pos >= PAIR_DEPTH) return 1'b0;
      was = buddy_bit[pos];
      buddy_bit[pos] = ~was;
      return was;
   endfunction

   function automatic void list_push(int page, int lvl);
      logic [LINK_W-1:0] h;
      h = free_head[lvl];
      fwd_link[page] = h;
      back_link[page] = '0;
      if (h != 0) back_link[h - 1] = LINK_W'(page + 1);
      free_head[lvl] = LINK_W'(page + 1);
   endfunction

   function automatic void list_remove(int page, int lvl);
      logic [LINK_W-1:0] n, p;
      n = fwd_link[page];
      p = back_link[page];
      if (p == 0) free_head[lvl] = n;
      else fwd_link[p - 1] = n;
      if (n != 0) back_link[n - 1] = p;
   endfunction

   function automatic alloc_result_t serve(logic kind, logic [ORD_W-1:0] ord,
                                           logic [PAGE_W-1:0] idx);
      alloc_result_t r;
      int page, cur, lvl, blk;
      r.idx = '0;
      r.st  = ST_OK;
      if (ord >= MAX_ORDERS) begin
         r.st = ST_ORDER;
      end else if (kind == REQ_ALLOC) begin
         r.st = ST_NO_FREE;
         for (lvl = ord; lvl < MAX_ORDERS; lvl++) begin
            if (free_head[lvl] != 0) begin
               page = free_head[lvl] - 1;
               list_remove(page, lvl);
               if (lvl != TOP_LVL) void'(flip_buddy(lvl, page));
               cur = lvl;
               while (cur > ord) begin
                  cur--;
                  list_push(page, cur);
                  void'(flip_buddy(cur, page));
                  page += 1 << cur;
               end
               r.idx = PAGE_W'(page);
               r.st  = ST_OK;
               break;
            end
         end
      end else if ((idx & ((1 << ord) - 1)) != 0 || int'(idx) + (1 << ord) > NUM_PAGES) begin
         r.st = ST_MISALIGN;
      end else begin
         blk = idx;
         for (lvl = ord; lvl < TOP_LVL; lvl++) begin
            if (!flip_buddy(lvl, blk)) break;
            list_remove(blk ^ (1 << lvl), lvl);
            blk &= ~((1 << (lvl + 1)) - 1);
         end
         list_push(blk, lvl);
      end
      return r;
   endfunction

   assign waiting = pending_results.size();

   always @(posedge clock) begin
      alloc_result_t e;
      int acc;
      if (reset) begin
         acc = 0;
         for (int k = 0; k < MAX_ORDERS; k++) begin
            free_head[k] = '0;
            bit_base[k] = acc;
            acc += (NUM_PAGES + (2 << k) - 1) >> (k + 1);
         end
         for (int k = 0; k < NUM_PAGES; k++) begin
            fwd_link[k] = '0;
            back_link[k] = '0;
         end
         for (int k = 0; k < PAIR_DEPTH; k++) buddy_bit[k] = 1'b0;
         pending_results.delete();
         fails = 0;
      end else begin
         if (req.valid && req.ready)
            pending_results.push_back(serve(req.req_type, req.order, req.block_index));
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response idx=%0d status=%0d with no request waiting",
                        $realtime, rsp.block_index_res, rsp.status);
               fails++;
            end else begin
               e = pending_results.pop_front();
               if (rsp.block_index_res !== e.idx || rsp.status !== e.st) begin
                  $display("%0t: expected idx=%0d status=%0d, got idx=%0d status=%0d",
                           $realtime, e.idx, e.st, rsp.block_index_res, rsp.status);
                  fails++;
               end
            end
         end
      end
   end

endmodule

// ----- tb/buddy_page_allocator_tb.sv -----
// testbench top: drives allocate and free requests, throttles responses, gives the verdict
module buddy_page_allocator_tb;
   import bpa_pkg::*;

   localparam int NUM_ITEMS = 1500;

   logic clock;
   logic reset;
   int   fails;
   int   waiting;
   int   req_count;
   int   item_no;
   logic quiet;
   logic hold_req;

   logic [PAGE_W-1:0] owned_idx [$];
   logic [ORD_W-1:0]  owned_ord [$];
   logic              sent_kind [$];
   logic [ORD_W-1:0]  sent_ord  [$];

   bpa_req_if req_ch ();
   bpa_rsp_if rsp_ch ();

   buddy_page_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   buddy_page_allocator_checker checker_inst (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .fails   (fails),
      .waiting (waiting)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // bookkeeping of blocks we own, so that frees hit allocated blocks only
   always @(posedge clock) begin
      if (reset) begin
         req_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            req_count <= req_count + 1;
            sent_kind.push_back(req_ch.req_type);
            sent_ord.push_back(req_ch.order);
         end
         if (rsp_ch.valid && rsp_ch.ready && sent_kind.size() > 0) begin
            if (sent_kind[0] == REQ_ALLOC && rsp_ch.status == ST_OK) begin
               owned_idx.push_back(rsp_ch.block_index_res);
               owned_ord.push_back(sent_ord[0]);
            end
            void'(sent_kind.pop_front());
            void'(sent_ord.pop_front());
         end
      end
   end

   task automatic send(input logic kind, input logic [ORD_W-1:0] ord,
                       input logic [PAGE_W-1:0] idx);
      int n;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      n = req_count;
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.order       <= ord;
      req_ch.block_index <= idx;
      do @(negedge clock); while (req_count == n);
   endtask

   task automatic random_request();
      int pick, r;
      logic [ORD_W-1:0]  ord;
      logic [PAGE_W-1:0] idx;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         send(1'($urandom_range(0, 1)), ORD_W'($urandom_range(MAX_ORDERS, 15)),
              PAGE_W'($urandom));
      end else if (r < 8) begin
         ord = ORD_W'($urandom_range(1, TOP_LVL));
         idx = PAGE_W'($urandom);
         if ((idx & ((1 << ord) - 1)) == 0) idx[$urandom_range(0, ord - 1)] = 1'b1;
         send(REQ_FREE, ord, idx);
      end else if (owned_idx.size() > 0 && (r < 52 || owned_idx.size() > 40)) begin
         pick = $urandom_range(0, owned_idx.size() - 1);
         ord = owned_ord[pick];
         idx = owned_idx[pick];
         owned_idx[pick] = owned_idx[owned_idx.size() - 1];
         owned_ord[pick] = owned_ord[owned_ord.size() - 1];
         void'(owned_idx.pop_back());
         void'(owned_ord.pop_back());
         send(REQ_FREE, ord, idx);
      end else begin
         ord = (r < 85) ? ORD_W'($urandom_range(0, 3)) : ORD_W'($urandom_range(0, TOP_LVL));
         send(REQ_ALLOC, ord, PAGE_W'($urandom));
      end
   endtask

   initial begin
      reset              = 1'b1;
      quiet              = 1'b0;
      hold_req           = 1'b0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_ALLOC;
      req_ch.order       = '0;
      req_ch.block_index = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // the zone starts owned by us: free it whole to seed the top list
      send(REQ_FREE, 4'd10, 10'd0);
      send(REQ_ALLOC, 4'd0, 10'h3ff);
      send(REQ_ALLOC, 4'd10, 10'd0);
      send(REQ_ALLOC, 4'd3, 10'h2aa);
      send(REQ_ALLOC, 4'd9, 10'h155);
      send(REQ_ALLOC, 4'd1, 10'd0);
      send(REQ_ALLOC, 4'd15, 10'h3ff);
      send(REQ_ALLOC, 4'd11, 10'd0);
      send(REQ_FREE, 4'd12, 10'd0);
      send(REQ_FREE, 4'd14, 10'h3ff);
      send(REQ_FREE, 4'd1, 10'd1);
      send(REQ_FREE, 4'd10, 10'd512);
      send(REQ_FREE, 4'd5, 10'h3ff);
      send(REQ_ALLOC, 4'd8, 10'd0);
      send(REQ_ALLOC, 4'd0, 10'd0);
      send(REQ_ALLOC, 4'd2, 10'd0);

      for (item_no = 0; item_no < NUM_ITEMS; item_no++) begin
         if (item_no == 400) hold_req <= 1'b1;
         if (item_no == 800) begin
            req_ch.valid <= 1'b0;
            do @(negedge clock); while (waiting != 0);
         end
         if (item_no == NUM_ITEMS - 200) quiet <= 1'b1;
         random_request();
      end
      req_ch.valid <= 1'b0;

      while (waiting != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fails == 0 && waiting == 0) begin
         $display("buddy_page_allocator: match");
      end else begin
         $display("buddy_page_allocator: mismatch");
      end
      $finish;
   end

   // response side throttling, with one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ch.ready <= 1'b0;
            hold_req <= 1'b0;
            repeat (300) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   initial begin
      #(12 * 2_000_000);
      $display("buddy_page_allocator: mismatch");
      $finish;
   end

endmodule
